/* hdl/pqte_pkg.sv */
// Shared types, constants and helper functions for the piecewise quintic trajectory evaluator.
// Used by pqte_front, pqte_queue, pqte_back and the top level; depends on nothing.
package pqte_pkg;

	localparam int MaxPieces = 16;
	localparam int Dims      = 3;
	localparam int NCoef     = 6;
	localparam int CoefDepth = MaxPieces * NCoef * Dims;
	localparam int CoefAw    = $clog2(CoefDepth);

	// Command codes of an input beat.
	localparam logic [1:0] CMD_LOAD_COEF = 2'd0;
	localparam logic [1:0] CMD_LOAD_DUR  = 2'd1;
	localparam logic [1:0] CMD_EVAL      = 2'd2;

	localparam logic [2:0] ORDER_MAX = 3'd4;
	localparam logic [2:0] TOP_POWER = 3'd5;

	localparam logic signed [47:0] SMAX48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] SMIN48 = 48'sh8000_0000_0000;

	typedef enum logic [1:0] {
		OP_COEF,
		OP_DUR,
		OP_EVAL
	} op_t;

	// One classified work item as it travels from the front to the back.
	typedef struct packed {
		op_t                op;
		logic               wr_ok;
		logic [3:0]         piece;
		logic [CoefAw-1:0]  coef_addr;
		logic [47:0]        data;
		logic [31:0]        qtime;
		logic [2:0]         order;
	} item_t;

	// Flat address of coefficient k of one piece and dimension.
	function automatic logic [CoefAw-1:0] coef_addr(input logic [3:0] piece,
		input logic [2:0] k, input logic [1:0] dim);
		coef_addr = CoefAw'(piece) * CoefAw'(NCoef * Dims) + CoefAw'(k) * CoefAw'(Dims)
			+ CoefAw'(dim);
	endfunction

	// Derivative factor k!/(k-d)! for k >= d, zero below.
	function automatic logic [6:0] dfac(input logic [2:0] d, input logic [2:0] k);
		logic [6:0] f;
		f = 7'd0;
		case (d)
			3'd0: f = 7'd1;
			3'd1: f = 7'(k);
			3'd2: f = (k >= 3'd2) ? 7'(k) * 7'(k - 3'd1) : 7'd0;
			3'd3: f = (k >= 3'd3) ? 7'(k) * 7'(k - 3'd1) * 7'(k - 3'd2) : 7'd0;
			3'd4: f = (k == 3'd4) ? 7'd24 : ((k == 3'd5) ? 7'd120 : 7'd0);
			default: f = 7'd0;
		endcase
		dfac = f;
	endfunction

	// Clamp a wide signed value to the signed 48-bit range.
	function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
		logic signed [47:0] r;
		if (v > 56'(SMAX48))
			r = SMAX48;
		else if (v < 56'(SMIN48))
			r = SMIN48;
		else
			r = v[47:0];
		sat48 = r;
	endfunction

endpackage

/* hdl/pqte_front.sv */
// Front end: accepts input beats, classifies them and prepares queue items.
// Depends on pqte_pkg.
module pqte_front (
	input  logic                 start,
	input  logic                 busy,
	input  logic [1:0]           cmd,
	input  logic [3:0]           piece_sel,
	input  logic [2:0]           coeff_sel,
	input  logic [1:0]           dim_sel,
	input  logic signed [47:0]   load_value,
	input  logic [31:0]          query_time,
	input  logic [2:0]           deriv_order,
	output logic                 push,
	output pqte_pkg::item_t      item
);

	logic accept;

	assign accept = start && !busy;

	// Classify the beat; the unused command code produces no item.
	always_comb begin
		item           = '0;
		item.piece     = piece_sel;
		item.qtime     = query_time;
		item.order     = (deriv_order > pqte_pkg::ORDER_MAX) ? 3'd0 : deriv_order;
		item.coef_addr = pqte_pkg::coef_addr(piece_sel, coeff_sel, dim_sel);
		push           = 1'b0;
		case (cmd)
			pqte_pkg::CMD_LOAD_COEF: begin
				item.op    = pqte_pkg::OP_COEF;
				item.wr_ok = (coeff_sel < 3'(pqte_pkg::NCoef)) && (dim_sel < 2'(pqte_pkg::Dims));
				item.data  = load_value;
				push       = accept;
			end
			pqte_pkg::CMD_LOAD_DUR: begin
				item.op    = pqte_pkg::OP_DUR;
				item.wr_ok = 1'b1;
				// Durations are clamped into the unsigned 32-bit range.
				if (load_value < 48'sd0)
					item.data = 48'd0;
				else if (load_value > 48'sh0000_FFFF_FFFF)
					item.data = 48'h0000_FFFF_FFFF;
				else
					item.data = load_value;
				push = accept;
			end
			pqte_pkg::CMD_EVAL: begin
				item.op = pqte_pkg::OP_EVAL;
				push    = accept;
			end
			default: push = 1'b0;
		endcase
	end

endmodule

/* hdl/pqte_queue.sv */
// Two-entry queue between the front and the back end.
// Depends on pqte_pkg for the item type.
module pqte_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pqte_pkg::item_t      push_item,
	input  logic                 pop,
	output logic                 full,
	output logic                 not_empty,
	output pqte_pkg::item_t      head
);

	pqte_pkg::item_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	// Item storage.
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

endmodule

/* hdl/pqte_back.sv */
// Back end: stores durations and coefficients, searches the piece and runs Horner's rule.
// Depends on pqte_pkg.
module pqte_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [4:0]           piece_count,
	input  logic                 q_valid,
	input  pqte_pkg::item_t      head,
	output logic                 pop,
	output logic                 result_valid,
	output logic [3:0]           piece_index,
	output logic [1:0]           dim_index,
	output logic signed [47:0]   state_value,
	output logic                 last,
	output logic                 past_end,
	output logic                 is_ack
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRD,
		S_SCMP,
		S_TRD,
		S_TWAIT,
		S_C5A,
		S_C5B,
		S_M1,
		S_M2,
		S_M3
	} state_t;

	state_t                          state_q;
	logic [31:0]                     dur_mem [pqte_pkg::MaxPieces];
	logic signed [47:0]              coef_mem [pqte_pkg::CoefDepth];
	logic [31:0]                     dur_rd_q;
	logic signed [47:0]              coef_rd_q;
	logic [3:0]                      daddr_q;
	logic [pqte_pkg::CoefAw-1:0]     caddr_q;

	logic [31:0]                     qt_q;
	logic [2:0]                      ord_q;
	logic [4:0]                      k_q;
	logic [32:0]                     total_q;
	logic [3:0]                      piece_q;
	logic [31:0]                     t_q;
	logic                            past_q;
	logic [1:0]                      dim_q;
	logic [2:0]                      kk_q;
	logic signed [47:0]              acc_q;
	logic                            neg_q;
	logic [63:0]                     phi_q;
	logic [63:0]                     plo_q;
	logic signed [47:0]              mt_q;
	logic signed [55:0]              cf_q;

	logic [4:0]                      n_use;
	logic [32:0]                     next_tot;
	logic                            brk;
	logic [4:0]                      brk_k;
	logic [32:0]                     brk_tot;
	logic [47:0]                     mag;
	logic [64:0]                     q_sum;
	logic signed [47:0]              mt_next;
	logic signed [55:0]              coef_prod;
	logic signed [47:0]              acc_sum;

	// Pieces in use, clamped to one through the store depth.
	always_comb begin
		if (piece_count == 5'd0)
			n_use = 5'd1;
		else if (piece_count > 5'(pqte_pkg::MaxPieces))
			n_use = 5'(pqte_pkg::MaxPieces);
		else
			n_use = piece_count;
	end

	assign pop = (state_q == S_IDLE) && q_valid;

	// Duration and coefficient stores, both with registered reads.
	always_ff @(posedge clk) begin
		if (pop && head.op == pqte_pkg::OP_DUR && head.wr_ok)
			dur_mem[head.piece] <= head.data[31:0];
		dur_rd_q <= dur_mem[daddr_q];
	end

	always_ff @(posedge clk) begin
		if (pop && head.op == pqte_pkg::OP_COEF && head.wr_ok)
			coef_mem[head.coef_addr] <= head.data;
		coef_rd_q <= coef_mem[caddr_q];
	end

	// Search step: decide whether the running sum stops at this piece.
	always_comb begin
		next_tot = total_q + {1'b0, dur_rd_q};
		brk      = 1'b0;
		brk_k    = k_q;
		brk_tot  = total_q;
		if (next_tot > {1'b0, qt_q}) begin
			brk = 1'b1;
		end else if (k_q + 5'd1 >= n_use) begin
			brk     = 1'b1;
			brk_k   = k_q + 5'd1;
			brk_tot = next_tot;
		end
	end

	// Time product rounding and saturation, coefficient scaling and the Horner sum.
	always_comb begin
		mag       = acc_q[47] ? 48'(-acc_q) : 48'(acc_q);
		q_sum     = 65'(phi_q) + 65'((65'(plo_q) + 65'h8000) >> 16);
		if (neg_q)
			mt_next = (q_sum >= 65'(48'h8000_0000_0000)) ? pqte_pkg::SMIN48
				: -$signed(q_sum[47:0]);
		else
			mt_next = (q_sum > 65'(pqte_pkg::SMAX48)) ? pqte_pkg::SMAX48
				: $signed(q_sum[47:0]);
		coef_prod = 56'(coef_rd_q) * 56'(pqte_pkg::dfac(ord_q,
			(state_q == S_C5B) ? pqte_pkg::TOP_POWER : kk_q));
		acc_sum   = pqte_pkg::sat48(56'(mt_q) + cf_q);
	end

	// Sequencer and registered result outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			result_valid <= 1'b0;
			piece_index  <= 4'd0;
			dim_index    <= 2'd0;
			state_value  <= 48'sd0;
			last         <= 1'b0;
			past_end     <= 1'b0;
			is_ack       <= 1'b0;
			daddr_q      <= 4'd0;
			caddr_q      <= '0;
			qt_q         <= 32'd0;
			ord_q        <= 3'd0;
			k_q          <= 5'd0;
			total_q      <= 33'd0;
			piece_q      <= 4'd0;
			t_q          <= 32'd0;
			past_q       <= 1'b0;
			dim_q        <= 2'd0;
			kk_q         <= 3'd0;
			acc_q        <= 48'sd0;
			neg_q        <= 1'b0;
			phi_q        <= 64'd0;
			plo_q        <= 64'd0;
			mt_q         <= 48'sd0;
			cf_q         <= 56'sd0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (head.op == pqte_pkg::OP_EVAL) begin
							qt_q   <= head.qtime;
							ord_q  <= head.order;
							past_q <= 1'b0;
							dim_q  <= 2'd0;
							if (head.qtime == 32'd0) begin
								piece_q <= 4'd0;
								t_q     <= 32'd0;
								caddr_q <= pqte_pkg::coef_addr(4'd0, pqte_pkg::TOP_POWER, 2'd0);
								state_q <= S_C5A;
							end else begin
								k_q     <= 5'd0;
								total_q <= 33'd0;
								daddr_q <= 4'd0;
								state_q <= S_SRD;
							end
						end else begin
							// Load acknowledge beat.
							result_valid <= 1'b1;
							piece_index  <= 4'd0;
							dim_index    <= 2'd0;
							state_value  <= 48'sd0;
							last         <= 1'b1;
							past_end     <= 1'b0;
							is_ack       <= 1'b1;
						end
					end
				end
				S_SRD: state_q <= S_SCMP;
				S_SCMP: begin
					if (!brk) begin
						total_q <= next_tot;
						k_q     <= k_q + 5'd1;
						daddr_q <= 4'(k_q + 5'd1);
						state_q <= S_SRD;
					end else if (brk_tot == {1'b0, qt_q}) begin
						// On a boundary: the earlier piece at its full duration.
						piece_q <= 4'(brk_k - 5'd1);
						daddr_q <= 4'(brk_k - 5'd1);
						state_q <= S_TRD;
					end else if (brk_k >= n_use) begin
						// Past the end: clamp to the end of the last piece.
						piece_q <= 4'(n_use - 5'd1);
						daddr_q <= 4'(n_use - 5'd1);
						past_q  <= 1'b1;
						state_q <= S_TRD;
					end else begin
						piece_q <= brk_k[3:0];
						t_q     <= qt_q - brk_tot[31:0];
						caddr_q <= pqte_pkg::coef_addr(brk_k[3:0], pqte_pkg::TOP_POWER, 2'd0);
						state_q <= S_C5A;
					end
				end
				S_TRD: state_q <= S_TWAIT;
				S_TWAIT: begin
					t_q     <= dur_rd_q;
					caddr_q <= pqte_pkg::coef_addr(piece_q, pqte_pkg::TOP_POWER, 2'd0);
					state_q <= S_C5A;
				end
				S_C5A: state_q <= S_C5B;
				S_C5B: begin
					acc_q   <= pqte_pkg::sat48(coef_prod);
					kk_q    <= 3'd4;
					caddr_q <= pqte_pkg::coef_addr(piece_q, 3'd4, dim_q);
					state_q <= S_M1;
				end
				S_M1: begin
					neg_q   <= acc_q[47];
					phi_q   <= 64'(mag) * 64'(t_q[31:16]);
					plo_q   <= 64'(mag) * 64'(t_q[15:0]);
					state_q <= S_M2;
				end
				S_M2: begin
					mt_q    <= mt_next;
					cf_q    <= coef_prod;
					state_q <= S_M3;
				end
				S_M3: begin
					acc_q <= acc_sum;
					if (kk_q == ord_q) begin
						result_valid <= 1'b1;
						piece_index  <= piece_q;
						dim_index    <= dim_q;
						state_value  <= acc_sum;
						last         <= (dim_q == 2'(pqte_pkg::Dims - 1));
						past_end     <= past_q;
						is_ack       <= 1'b0;
						if (dim_q == 2'(pqte_pkg::Dims - 1)) begin
							state_q <= S_IDLE;
						end else begin
							dim_q   <= dim_q + 2'd1;
							caddr_q <= pqte_pkg::coef_addr(piece_q, pqte_pkg::TOP_POWER,
								dim_q + 2'd1);
							state_q <= S_C5A;
						end
					end else begin
						kk_q    <= kk_q - 3'd1;
						caddr_q <= pqte_pkg::coef_addr(piece_q, kk_q - 3'd1, dim_q);
						state_q <= S_M1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hdl/piecewise_quintic_trajectory_eval.sv */
// Top level of the piecewise quintic trajectory evaluator.
// Depends on pqte_pkg, pqte_front, pqte_queue and pqte_back.
//
// Usage: an input beat is taken at a rising edge with start high and busy low.
// cmd selects a coefficient load, a duration load or an evaluation; the unused
// command code is dropped without a result. Beats pass through a two-entry queue,
// so busy rises only when that queue is full.
// Each load gives one acknowledge beat (is_ack and last high), registered once the
// idle back end takes it from the queue. An evaluation gives three result beats,
// one per dimension, the third with last high. An evaluation leaves idle, searches
// the pieces, settles the local time on a boundary or past the end, then per
// dimension scales the top coefficient and runs each Horner step (5 minus the
// order steps), each through the split 48x16 time product; items are worked on
// one at a time.
// Results are held on the output ports for one cycle, marked by result_valid; the
// receiver cannot stall them.
// Reset empties the queue, returns the back end to idle and sets piece_count to 1;
// the coefficient and duration stores hold nothing defined until written.
module piecewise_quintic_trajectory_eval (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [4:0]           cfg_wdata,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           cmd,
	input  logic [3:0]           piece_sel,
	input  logic [2:0]           coeff_sel,
	input  logic [1:0]           dim_sel,
	input  logic signed [47:0]   load_value,
	input  logic [31:0]          query_time,
	input  logic [2:0]           deriv_order,
	output logic                 result_valid,
	output logic [3:0]           piece_index,
	output logic [1:0]           dim_index,
	output logic signed [47:0]   state_value,
	output logic                 last,
	output logic                 past_end,
	output logic                 is_ack
);

	logic                  piece_count_q;
	logic [4:0]            piece_cnt_q;
	logic                  push;
	logic                  pop;
	logic                  q_valid;
	pqte_pkg::item_t       push_item;
	pqte_pkg::item_t       head;

	// Piece count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piece_cnt_q   <= 5'd1;
			piece_count_q <= 1'b0;
		end else if (cfg_we) begin
			piece_cnt_q   <= cfg_wdata;
			piece_count_q <= 1'b1;
		end
	end

	pqte_front u_front (
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.piece_sel   (piece_sel),
		.coeff_sel   (coeff_sel),
		.dim_sel     (dim_sel),
		.load_value  (load_value),
		.query_time  (query_time),
		.deriv_order (deriv_order),
		.push        (push),
		.item        (push_item)
	);

	pqte_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (busy),
		.not_empty (q_valid),
		.head      (head)
	);

	pqte_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.piece_count  (piece_count_q ? piece_cnt_q : 5'd1),
		.q_valid      (q_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.piece_index  (piece_index),
		.dim_index    (dim_index),
		.state_value  (state_value),
		.last         (last),
		.past_end     (past_end),
		.is_ack       (is_ack)
	);

endmodule

/* tb/piecewise_quintic_trajectory_eval_tb.sv */
// Testbench for the piecewise quintic trajectory evaluator: loads, queries and piece count.
// Depends on pqte_pkg and piecewise_quintic_trajectory_eval; carries its own trajectory predictor.
`timescale 1ns / 100ps

module piecewise_quintic_trajectory_eval_tb;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 120;

	// One expected result beat.
	typedef struct {
		logic [3:0]         piece;
		logic [1:0]         dim;
		logic signed [47:0] value;
		logic               last;
		logic               past;
		logic               ack;
	} traj_beat_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [4:0]         cfg_wdata;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic [3:0]         piece_sel;
	logic [2:0]         coeff_sel;
	logic [1:0]         dim_sel;
	logic signed [47:0] load_value;
	logic [31:0]        query_time;
	logic [2:0]         deriv_order;
	logic               result_valid;
	logic [3:0]         piece_index;
	logic [1:0]         dim_index;
	logic signed [47:0] state_value;
	logic               last;
	logic               past_end;
	logic               is_ack;

	// Predictor state: the stores and the piece count register.
	logic signed [47:0] coef_shadow [pqte_pkg::CoefDepth];
	logic [31:0]        dur_shadow [pqte_pkg::MaxPieces];
	logic [4:0]         pieces_reg;

	traj_beat_t pending_beats [$];
	int         error_count;
	int         cycle_count;
	int         sender_idle_pct;

	piecewise_quintic_trajectory_eval DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .cmd(cmd), .piece_sel(piece_sel),
		.coeff_sel(coeff_sel), .dim_sel(dim_sel), .load_value(load_value),
		.query_time(query_time), .deriv_order(deriv_order),
		.result_valid(result_valid), .piece_index(piece_index), .dim_index(dim_index),
		.state_value(state_value), .last(last), .past_end(past_end), .is_ack(is_ack)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Derivative factor k!/(k-d)!.
	function automatic longint deriv_factor(int d, int k);
		longint f;
		int i;
		f = 1;
		if (k < d)
			return 0;
		for (i = 0; i < d; i++)
			f = f * (k - i);
		return f;
	endfunction

	function automatic logic signed [47:0] clamp48(longint v);
		if (v > longint'(pqte_pkg::SMAX48))
			return pqte_pkg::SMAX48;
		if (v < longint'(pqte_pkg::SMIN48))
			return pqte_pkg::SMIN48;
		return v[47:0];
	endfunction

	// Accumulator times Q16.16 time, rounded half away from zero, saturated.
	function automatic logic signed [47:0] scale_by_time(logic signed [47:0] acc, logic [31:0] t);
		logic [79:0] mag;
		logic [79:0] q;
		mag = (acc < 0) ? 80'(-longint'(acc)) : 80'(longint'(acc));
		q = mag * 80'(t[31:16]) + ((mag * 80'(t[15:0]) + 80'h8000) >> 16);
		if (acc < 0)
			return (q >= 80'(1) << 47) ? pqte_pkg::SMIN48 : clamp48(-longint'(q[63:0]));
		return (q > 80'(pqte_pkg::SMAX48)) ? pqte_pkg::SMAX48 : clamp48(longint'(q[63:0]));
	endfunction

	// Work out the result beats that one accepted beat causes.
	task automatic predict_beat(logic [1:0] c, logic [3:0] ps, logic [2:0] cs, logic [1:0] ds,
		logic signed [47:0] lv, logic [31:0] qt, logic [2:0] order);
		traj_beat_t b;
		int n;
		int d;
		int k;
		int j;
		int piece;
		logic [31:0] t;
		logic past;
		longint total;
		longint nxt;
		logic signed [47:0] acc;
		b = '{piece: 0, dim: 0, value: 0, last: 1, past: 0, ack: 1};
		if (c == pqte_pkg::CMD_LOAD_COEF || c == pqte_pkg::CMD_LOAD_DUR) begin
			if (c == pqte_pkg::CMD_LOAD_COEF) begin
				if (cs < pqte_pkg::NCoef && ds < pqte_pkg::Dims)
					coef_shadow[(ps * pqte_pkg::NCoef + cs) * pqte_pkg::Dims + ds] = lv;
			end else if (lv < 0) begin
				dur_shadow[ps] = 32'd0;
			end else if (longint'(lv) > 64'hFFFF_FFFF) begin
				dur_shadow[ps] = 32'hFFFF_FFFF;
			end else begin
				dur_shadow[ps] = lv[31:0];
			end
			pending_beats.push_back(b);
			return;
		end
		if (c != pqte_pkg::CMD_EVAL)
			return;
		n = (pieces_reg < 1) ? 1 : ((pieces_reg > pqte_pkg::MaxPieces) ? pqte_pkg::MaxPieces
			: pieces_reg);
		d = (order > pqte_pkg::ORDER_MAX) ? 0 : order;
		piece = 0;
		t = 0;
		past = 0;
		if (qt != 0) begin
			total = 0;
			k = 0;
			while (k < n) begin
				nxt = total + dur_shadow[k];
				if (nxt > longint'(qt))
					break;
				total = nxt;
				k++;
			end
			if (total == longint'(qt)) begin
				piece = k - 1;
				t = dur_shadow[piece];
			end else if (k >= n) begin
				piece = n - 1;
				t = dur_shadow[piece];
				past = 1;
			end else begin
				piece = k;
				t = 32'(longint'(qt) - total);
			end
		end
		for (j = 0; j < pqte_pkg::Dims; j++) begin
			acc = clamp48(longint'(coef_shadow[(piece * pqte_pkg::NCoef + 5) * pqte_pkg::Dims + j])
				* deriv_factor(d, 5));
			for (k = 4; k >= d; k--)
				acc = clamp48(longint'(scale_by_time(acc, t))
					+ longint'(coef_shadow[(piece * pqte_pkg::NCoef + k) * pqte_pkg::Dims + j])
					* deriv_factor(d, k));
			b = '{piece: piece, dim: j, value: acc, last: (j == pqte_pkg::Dims - 1), past: past,
				ack: 0};
			pending_beats.push_back(b);
		end
	endtask

	// Send one beat, wait for its acceptance, then idle at random.
	task automatic send_beat(logic [1:0] c, logic [3:0] ps, logic [2:0] cs, logic [1:0] ds,
		logic signed [47:0] lv, logic [31:0] qt, logic [2:0] order);
		cmd <= c;
		piece_sel <= ps;
		coeff_sel <= cs;
		dim_sel <= ds;
		load_value <= lv;
		query_time <= qt;
		deriv_order <= order;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_beat(c, ps, cs, ds, lv, qt, order);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every expected beat has come, plus settling time.
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_piece_count(logic [4:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		pieces_reg = v;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [47:0] rand_coef();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(3))
			0: return r[47:0];
			1: return 48'(longint'($signed(r[31:0])));
			2: return 48'(longint'($signed(r[27:0])));
			default: return 48'(longint'($signed(r[35:0])));
		endcase
	endfunction

	function automatic logic [31:0] piece_total(int n);
		longint s;
		int i;
		s = 0;
		for (i = 0; i < n; i++)
			s += dur_shadow[i];
		return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(s);
	endfunction

	// Query times that land on zero, boundaries, inside pieces, past the end or at random.
	function automatic logic [31:0] rand_query();
		int n;
		int p;
		n = (pieces_reg < 1) ? 1 : ((pieces_reg > pqte_pkg::MaxPieces) ? pqte_pkg::MaxPieces
			: pieces_reg);
		p = $urandom_range(1, n);
		case ($urandom_range(9))
			0: return 32'd0;
			1: return $urandom;
			2: return piece_total(p);
			3: return piece_total(n) + $urandom_range(1, 70000);
			default: return piece_total(p - 1) + $urandom_range(0, dur_shadow[p - 1]);
		endcase
	endfunction

	// Fill every store entry so that no query reads an unwritten one.
	task automatic test_store_fill;
		int p;
		int k;
		int j;
		for (p = 0; p < pqte_pkg::MaxPieces; p++) begin
			send_beat(pqte_pkg::CMD_LOAD_DUR, p, 0, 0, $urandom_range(1, 200000), 0, 0);
			for (k = 0; k < pqte_pkg::NCoef; k++)
				for (j = 0; j < pqte_pkg::Dims; j++)
					send_beat(pqte_pkg::CMD_LOAD_COEF, p, k, j, rand_coef(), 0, 0);
		end
	endtask

	// Field extremes, every command, orders above four and the special loads.
	task automatic test_directed;
		int d;
		send_beat(pqte_pkg::CMD_LOAD_COEF, 0, 5, 0, pqte_pkg::SMAX48, 0, 0);
		send_beat(pqte_pkg::CMD_LOAD_COEF, 0, 4, 1, pqte_pkg::SMIN48, 0, 0);
		send_beat(pqte_pkg::CMD_LOAD_COEF, 15, 6, 0, 48'sd5, 0, 0);
		send_beat(pqte_pkg::CMD_LOAD_COEF, 15, 7, 3, -48'sd1, 32'hFFFF_FFFF, 3'd7);
		send_beat(pqte_pkg::CMD_LOAD_DUR, 0, 0, 0, -48'sd7, 0, 0);
		send_beat(pqte_pkg::CMD_LOAD_DUR, 0, 0, 0, 48'sh1_0000_0000, 0, 0);
		send_beat(CMD_UNUSED, 4'hF, 3'h7, 2'h3, -48'sd1, 32'hFFFF_FFFF, 3'd7);
		for (d = 0; d < 8; d++)
			send_beat(pqte_pkg::CMD_EVAL, 0, 0, 0, 0, 32'h0001_8000, d);
		send_beat(pqte_pkg::CMD_EVAL, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
		send_beat(pqte_pkg::CMD_EVAL, 0, 0, 0, 0, 32'd0, 1);
		send_beat(pqte_pkg::CMD_LOAD_DUR, 0, 0, 0, 48'h0002_0000, 0, 0);
		send_beat(pqte_pkg::CMD_EVAL, 0, 0, 0, 0, 32'h0002_0000, 2);
		send_beat(pqte_pkg::CMD_EVAL, 0, 0, 0, 0, 32'h0002_0001, 0);
		send_beat(pqte_pkg::CMD_LOAD_COEF, 0, 0, 2, 48'sd1, 0, 0);
		send_beat(pqte_pkg::CMD_EVAL, 0, 0, 0, 0, 32'd1, 4);
		drain();
	endtask

	// Random mix: mostly queries over the loaded trajectory, some loads.
	task automatic test_random(int count);
		int i;
		logic [63:0] r;
		for (i = 0; i < count; i++) begin
			r = {$urandom, $urandom};
			case ($urandom_range(9))
				0: send_beat(pqte_pkg::CMD_LOAD_COEF, r[3:0], $urandom_range(7),
					$urandom_range(3), rand_coef(), $urandom, $urandom_range(7));
				1: send_beat(pqte_pkg::CMD_LOAD_DUR, r[3:0], 0, 0,
					($urandom_range(7) == 0) ? r[47:0] : 48'($urandom_range(0, 200000)),
					0, 0);
				default: send_beat(pqte_pkg::CMD_EVAL, r[3:0], r[6:4], r[8:7], r[55:8],
					rand_query(), $urandom_range(7));
			endcase
		end
	endtask

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		traj_beat_t e;
		if (arst_n && result_valid) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected result beat piece %0d dim %0d value %0d", $time,
					piece_index, dim_index, state_value);
				error_count++;
			end else begin
				e = pending_beats.pop_front();
				if (piece_index !== e.piece || dim_index !== e.dim
					|| state_value !== e.value || last !== e.last
					|| past_end !== e.past || is_ack !== e.ack) begin
					$display("%0t: expected piece %0d dim %0d value %0d last %0b past %0b ack %0b",
						$time, e.piece, e.dim, e.value, e.last, e.past, e.ack);
					$display("%0t:   actual piece %0d dim %0d value %0d last %0b past %0b ack %0b",
						$time, piece_index, dim_index, state_value, last, past_end, is_ack);
					error_count++;
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		cycle_count = 0;
		sender_idle_pct = 0;
		pieces_reg = 5'd1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 5'd0;
		start = 1'b0;
		cmd = pqte_pkg::CMD_LOAD_COEF;
		piece_sel = 0;
		coeff_sel = 0;
		dim_sel = 0;
		load_value = 0;
		query_time = 0;
		deriv_order = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_store_fill();
		drain();
		write_piece_count(5'd1);
		test_directed();

		write_piece_count(5'd16);
		sender_idle_pct = 0;
		test_random(35);
		drain();

		write_piece_count(5'd0);
		sender_idle_pct = 57;
		test_random(25);
		drain();

		write_piece_count(5'd31);
		sender_idle_pct = 26;
		test_random(25);
		drain();

		write_piece_count(5'd5);
		sender_idle_pct = 57;
		test_random(25);
		drain();

		write_piece_count(5'd17);
		sender_idle_pct = 0;
		test_random(20);
		drain();

		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
hdl/pqte_pkg.sv
hdl/pqte_front.sv
hdl/pqte_queue.sv
hdl/pqte_back.sv
hdl/piecewise_quintic_trajectory_eval.sv
tb/piecewise_quintic_trajectory_eval_tb.sv
